// ----- rtl/cht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// shared types, sizes and constants of the chained hash table unit
// ----------------------------------------------------------------------------
package cht_pkg;

   // table geometry
   localparam int BUCKETS   = 64;
   localparam int NODES     = 256;
   localparam int KEY_WIDTH = 16;   // used low bits of the key field, at most the field width

   // fixed field widths
   localparam int KEY_FIELD_W = 16;
   localparam int CMP_W       = 9;
   localparam int CSR_W       = 7;

   // derived sizes
   localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int DIV_W      = $clog2(BUCKETS + 1);
   localparam int NODE_AW    = $clog2(NODES);
   localparam int NODE_IW    = $clog2(NODES + 1);   // node index incl. the end-of-chain value
   localparam int MOD_STEPS  = (KEY_WIDTH + 1) / 2; // two quotient bits per cycle
   localparam int KEY_PAD_W  = 2 * MOD_STEPS;
   localparam int MOD_CNT_W  = $clog2(MOD_STEPS + 1);

   localparam logic [NODE_IW-1:0] NIL_NODE  = NODE_IW'(NODES);
   localparam logic [CMP_W-1:0]   CMP_MAX   = {CMP_W{1'b1}};
   localparam logic [CSR_W-1:0]   BUCKET_COUNT_RESET = CSR_W'(10);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [KEY_FIELD_W-1:0] key;
   } req_payload_type;

   typedef struct packed {
      logic             found;
      logic [CMP_W-1:0] comparisons;
      logic             status;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic head_rd;
      logic set_full;
      logic ins_commit;
      logic walk_init;
      logic node_rd;
      logic node_cmp;
      logic out_load;
   } cht_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mod_busy;
      logic is_search;
      logic pool_full;
      logic walk_end;
      logic key_match;
      logic rsp_free;
   } cht_status_type;

endpackage
`default_nettype wire

// ----- rtl/cht_mod_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_mod_unit
// iterative remainder of key by bucket count, two bits per cycle
// ----------------------------------------------------------------------------
module cht_mod_unit
   import cht_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [KEY_WIDTH-1:0] dividend,
   input  wire logic [DIV_W-1:0]     divisor,
   output logic                      busy,
   output logic [DIV_W-1:0]          remainder
);

   logic [DIV_W-1:0]     div_ff;
   logic [KEY_PAD_W-1:0] shift_ff, shift_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [MOD_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;

   logic [DIV_W:0] t1, t2, r1, r2;

   always_comb begin
      t1 = {rem_ff, shift_ff[KEY_PAD_W-1]};
      r1 = (t1 >= {1'b0, div_ff}) ? (t1 - {1'b0, div_ff}) : t1;
      t2 = {r1[DIV_W-1:0], shift_ff[KEY_PAD_W-2]};
      r2 = (t2 >= {1'b0, div_ff}) ? (t2 - {1'b0, div_ff}) : t2;
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         shift_in = KEY_PAD_W'(dividend);
         rem_in   = '0;
         count_in = MOD_CNT_W'(MOD_STEPS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[KEY_PAD_W-3:0], 2'b00};
         rem_in   = r2[DIV_W-1:0];
         count_in = count_ff - MOD_CNT_W'(1);
         busy_in  = (count_ff != MOD_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ----- rtl/cht_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_datapath
// bucket heads, node pool, chain walk registers and result register
// ----------------------------------------------------------------------------
module cht_datapath
   import cht_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cht_cmd_type     cmd,
   output cht_status_type       sts,
   input  wire req_payload_type req_data,
   input  wire logic            csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   // configuration
   logic [CSR_W-1:0] bucket_count_ff;
   logic [31:0]      bc_wide, div_wide;
   logic [DIV_W-1:0] divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else if (csr_wr_en) begin
         bucket_count_ff <= csr_wr_data;
      end
   end

   // zero means one bucket, above the table size saturates
   always_comb begin
      bc_wide = 32'(bucket_count_ff);
      if (bc_wide == 32'd0) begin
         div_wide = 32'd1;
      end else if (bc_wide > 32'(BUCKETS)) begin
         div_wide = 32'(BUCKETS);
      end else begin
         div_wide = bc_wide;
      end
      divisor = DIV_W'(div_wide);
   end

   // item registers
   logic                 cmd_ff;
   logic [KEY_WIDTH-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_data.cmd;
         key_ff <= req_data.key[KEY_WIDTH-1:0];
      end
   end

   // hash
   logic             mod_busy;
   logic [DIV_W-1:0] remainder;
   logic [BKT_W-1:0] bucket;

   cht_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load),
      .dividend  (req_data.key[KEY_WIDTH-1:0]),
      .divisor   (divisor),
      .busy      (mod_busy),
      .remainder (remainder)
   );

   assign bucket = remainder[BKT_W-1:0];

   // pool fill count and walk pointer
   logic [NODE_IW-1:0] nodes_used_ff, nodes_used_in;
   logic [NODE_IW-1:0] cur_ff, cur_in;

   // bucket heads: memory plus a valid bit per bucket
   logic [NODE_IW-1:0] head_mem [BUCKETS];
   logic [NODE_IW-1:0] head_data_ff;
   logic [BUCKETS-1:0] head_valid_ff, head_valid_in;
   logic               head_vld_ff, head_vld_in;
   logic [NODE_IW-1:0] head_eff;

   always_ff @(posedge clock) begin
      if (cmd.head_rd) begin
         head_data_ff <= head_mem[bucket];
      end
      if (cmd.ins_commit) begin
         head_mem[bucket] <= nodes_used_ff;
      end
   end

   always_comb begin
      head_valid_in = head_valid_ff;
      head_vld_in   = head_vld_ff;
      if (cmd.ins_commit) begin
         head_valid_in[bucket] = 1'b1;
      end
      if (cmd.head_rd) begin
         head_vld_in = head_valid_ff[bucket];
      end
   end

   assign head_eff = head_vld_ff ? head_data_ff : NIL_NODE;

   // node pool
   logic [KEY_WIDTH-1:0] node_key_mem  [NODES];
   logic [NODE_IW-1:0]   node_link_mem [NODES];
   logic [KEY_WIDTH-1:0] node_key_ff;
   logic [NODE_IW-1:0]   node_link_ff;

   always_ff @(posedge clock) begin
      if (cmd.ins_commit) begin
         node_key_mem[nodes_used_ff[NODE_AW-1:0]]  <= key_ff;
         node_link_mem[nodes_used_ff[NODE_AW-1:0]] <= head_eff;
      end
      if (cmd.node_rd) begin
         node_key_ff  <= node_key_mem[cur_ff[NODE_AW-1:0]];
         node_link_ff <= node_link_mem[cur_ff[NODE_AW-1:0]];
      end
   end

   // walk and result scratch
   logic [NODE_IW-1:0] steps_ff, steps_in;
   logic [CMP_W-1:0]   cmps_ff, cmps_in;
   logic               found_ff, found_in;
   logic               full_ff, full_in;
   logic               key_match;

   assign key_match = (node_key_ff == key_ff);

   always_comb begin
      nodes_used_in = nodes_used_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      cmps_in       = cmps_ff;
      found_in      = found_ff;
      full_in       = full_ff;
      if (cmd.load) begin
         steps_in = '0;
         cmps_in  = '0;
         found_in = 1'b0;
         full_in  = 1'b0;
      end
      if (cmd.set_full) begin
         full_in = 1'b1;
      end
      if (cmd.ins_commit) begin
         nodes_used_in = nodes_used_ff + NODE_IW'(1);
      end
      if (cmd.walk_init) begin
         cur_in = head_eff;
      end
      if (cmd.node_cmp) begin
         steps_in = steps_ff + NODE_IW'(1);
         cmps_in  = (cmps_ff == CMP_MAX) ? cmps_ff : cmps_ff + CMP_W'(1);
         if (key_match) begin
            found_in = 1'b1;
         end else begin
            cur_in = node_link_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         nodes_used_ff <= '0;
      end else begin
         head_valid_ff <= head_valid_in;
         nodes_used_ff <= nodes_used_in;
      end
   end

   always_ff @(posedge clock) begin
      head_vld_ff <= head_vld_in;
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      cmps_ff     <= cmps_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
   end

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.found       <= found_ff;
         rsp_data_ff.comparisons <= cmps_ff;
         rsp_data_ff.status      <= full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status
   always_comb begin
      sts.mod_busy  = mod_busy;
      sts.is_search = (cmd_ff == OP_SEARCH);
      sts.pool_full = (nodes_used_ff >= NODE_IW'(NODES));
      sts.walk_end  = (cur_ff >= NIL_NODE) || (steps_ff >= NODE_IW'(NODES));
      sts.key_match = key_match;
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire

// ----- rtl/cht_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ctrl
// sequencer for hash, head lookup, insert and chain walk
// ----------------------------------------------------------------------------
module cht_ctrl
   import cht_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire cht_status_type sts,
   output cht_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MOD  = 3'd1;
   localparam logic [2:0] S_HEAD = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_NODE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (!sts.mod_busy) begin
               cmd.head_rd = 1'b1;
               state_in    = S_HEAD;
            end
         end
         S_HEAD: begin
            if (sts.is_search) begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK;
            end else if (sts.pool_full) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.ins_commit = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_WALK: begin
            if (sts.walk_end) begin
               state_in = S_DONE;
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = S_NODE;
            end
         end
         S_NODE: begin
            cmd.node_cmp = 1'b1;
            state_in     = sts.key_match ? S_DONE : S_WALK;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/chained_hash_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// separate-chaining hash table with a fixed node pool, insert and search
// ----------------------------------------------------------------------------
// order: remainder, bucket head read, then an insert commit or a chain walk that
//   reads and compares one node at a time, then the response register
// throughput: one item at a time, set by the remainder unit (two bits per
//   cycle) and the chain walk
// reset: synchronous, empties all buckets and the pool, bucket count back to 10
// ----------------------------------------------------------------------------
module chained_hash_table_unit
   import cht_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request beats
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_data,
   // response beats
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_payload_type       rsp_data,
   // bucket count register
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   // command and status between sequencer and datapath
   cht_cmd_type    cmd;
   cht_status_type sts;

   // sequencer: one request in flight, waits on the hash, the head read,
   // then either commits an insert, flags a full pool on an insert that
   // finds no free node, or walks the chain node by node; the finished beat
   // is parked in the response register so a new request may be taken while the previous response waits
   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: remainder unit, bucket head memory with valid bits,
   // node key and link memories filled in order, walk counters and
   // the response register
   cht_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // a dropped insert reports neither a hit nor any comparison
   a_full_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (!rsp_data.found && rsp_data.comparisons == '0))
      else $error("full status with search fields set");

   // a hit always costs at least one comparison
   a_found_cmp : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.comparisons != '0))
      else $error("found without comparisons");

   // once a request is taken the sequencer is busy the next cycle
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in flight");

endmodule
`default_nettype wire
